// ===== rtl/wfms_pkg.sv =====
// ----------------------------------------------------------------------------
// wfms_pkg
// Shared types, constants and tables of the windowed FFT magnitude spectrum.
// ----------------------------------------------------------------------------
package wfms_pkg;

   // sine rom geometry: 128 points per turn, quarter wave stored
   localparam int ROM_BITS = 7;
   localparam int ROM_QUARTER = 32;

   localparam logic [29:0] MAG_MAX = 30'h3FFF_FFFF;
   localparam logic [63:0] LN2_Q30 = 64'd744261118;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WINDOW_ENABLE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_EQUALIZE_ENABLE = 2'd1;

   // sequencer states
   typedef enum logic [19:0] {
      ST_IDLE     = 20'h00001,
      ST_LD_MUL   = 20'h00002,
      ST_LD_WR    = 20'h00004,
      ST_BF_RB    = 20'h00008,
      ST_BF_RA    = 20'h00010,
      ST_BF_M0    = 20'h00020,
      ST_BF_M1    = 20'h00040,
      ST_BF_M2    = 20'h00080,
      ST_BF_M3    = 20'h00100,
      ST_BF_M4    = 20'h00200,
      ST_BF_WA    = 20'h00400,
      ST_BF_WB    = 20'h00800,
      ST_OUT_RD   = 20'h01000,
      ST_OUT_SQ0  = 20'h02000,
      ST_OUT_SQ1  = 20'h04000,
      ST_OUT_SUM  = 20'h08000,
      ST_OUT_SQRT = 20'h10000,
      ST_OUT_EQ   = 20'h20000,
      ST_OUT_SAT  = 20'h40000,
      ST_OUT_HOLD = 20'h80000
   } state_type;

   // quarter sine, q1.15, saturated at the peak
   localparam logic signed [16:0] QUARTER_SINE [ROM_QUARTER+1] = '{
      17'sd0,     17'sd1608,  17'sd3212,  17'sd4808,  17'sd6393,  17'sd7962,
      17'sd9512,  17'sd11039, 17'sd12540, 17'sd14010, 17'sd15447, 17'sd16846,
      17'sd18205, 17'sd19520, 17'sd20788, 17'sd22006, 17'sd23170, 17'sd24279,
      17'sd25330, 17'sd26320, 17'sd27246, 17'sd28106, 17'sd28899, 17'sd29622,
      17'sd30274, 17'sd30853, 17'sd31357, 17'sd31786, 17'sd32138, 17'sd32413,
      17'sd32610, 17'sd32729, 17'sd32767
   };

   // full-wave sine from the quarter table
   function automatic logic signed [16:0] sin_rom(input logic [ROM_BITS-1:0] k);
      logic [1:0] q;
      logic [5:0] r;
      logic signed [16:0] v;
      q = k[6:5];
      r = {1'b0, k[4:0]};
      v = q[0] ? QUARTER_SINE[6'd32 - r] : QUARTER_SINE[r];
      return q[1] ? -v : v;
   endfunction

   // shift-subtract division, elaboration use only
   function automatic logic [63:0] udiv64(input logic [63:0] num,
                                          input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // natural log in q30: exponent times ln2 plus an atanh series
   function automatic logic [63:0] ln_q30(input logic [31:0] k);
      logic [63:0] e, z, z2, p, sum, pw;
      e = '0;
      if (k == 32'd0) begin
         return 64'd0;
      end
      for (int b = 0; b < 32; b++) begin
         if (k[b]) begin
            e = 64'(b);
         end
      end
      pw = 64'd1 << e;
      z = udiv64((64'(k) - pw) << 30, 64'(k) + pw);
      z2 = (z * z) >> 30;
      sum = z;
      p = z;
      for (int n = 1; n <= 10; n++) begin
         p = (p * z2) >> 30;
         sum = sum + udiv64(p, 64'(2 * n + 1));
      end
      return e * LN2_Q30 + (sum << 1);
   endfunction

   // q0.16 equalize factor 0.02*ln(h/(h-i)), rounded
   function automatic logic [15:0] eq_value(input logic [31:0] h,
                                            input logic [31:0] i);
      logic [63:0] d;
      d = ln_q30(h) - ln_q30(h - i);
      return 16'((d + 64'd409600) / 64'd819200);
   endfunction

endpackage

// ===== rtl/wfms_ram.sv =====
// ----------------------------------------------------------------------------
// wfms_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module wfms_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/wfms_isqrt.sv =====
// ----------------------------------------------------------------------------
// wfms_isqrt
// Iterative floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module wfms_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] value,
   output logic        done,
   output logic [31:0] root
);

   logic [63:0] rem_ff, rem_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic [4:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] trial;

   // one digit per cycle
   always_comb begin
      trial   = res_ff + bit_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = value;
         res_in  = '0;
         bit_in  = 64'd1 << 62;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in  = bit_ff >> 2;
         step_in = step_ff + 5'd1;
         if (step_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      step_ff <= step_in;
   end

   assign done = done_ff;
   assign root = res_ff[31:0];

endmodule

// ===== rtl/windowed_fft_magnitude_spectrum.sv =====
// ----------------------------------------------------------------------------
// windowed_fft_magnitude_spectrum
// Radix-2 FFT of one frame, Hann window optional, then bin magnitudes, equalising optional.
// ----------------------------------------------------------------------------
//  channel  direction  ports                                    transfer when
//  req      in         req_valid req_ready req_sample           valid & ready
//  rsp      out        rsp_valid rsp_ready rsp_bin_index,       valid & ready
//                      rsp_magnitude rsp_last_bin
//  csr      in         csr_valid csr_ready csr_index csr_wdata  valid & ready,
//                                                               ready when idle
//
//  Each sample makes one pass through the shared multiplier and one write into
//  the frame memory before the next is accepted. The last sample starts the
//  FFT: (FRAME_POINTS/2)*log2(FRAME_POINTS) butterflies, each two reads, four
//  multiplies and two writes, paced by the single memory port pair and the
//  shared multiplier. Each bin then waits on the 32-step square root unit and
//  on rsp. Reset is synchronous; the frame memory needs no clearing.
// ----------------------------------------------------------------------------
module windowed_fft_magnitude_spectrum #(
   parameter int FRAME_POINTS = 64,
   parameter int SAMPLE_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [15:0]                   req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [5:0]                           rsp_bin_index,
   output logic [29:0]                          rsp_magnitude,
   output logic                                 rsp_last_bin,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [wfms_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic                                 csr_wdata
);

   import wfms_pkg::*;

   localparam int LOG2   = $clog2(FRAME_POINTS);
   localparam int ADDR_W = LOG2;
   localparam int HALF   = FRAME_POINTS / 2;
   localparam int HW     = LOG2 - 1;

   state_type state_ff, state_in;

   logic [ADDR_W-1:0]             load_ff, load_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                          win_en_ff, win_en_in;
   logic                          eq_en_ff, eq_en_in;
   logic [2:0]                    stage_ff, stage_in;
   logic [HW-1:0]                 bfly_ff, bfly_in;
   logic [HW-1:0]                 bin_ff, bin_in;
   logic [63:0]                   a_ff, a_in;
   logic [63:0]                   b_ff, b_in;
   logic signed [49:0]            acc_ff, acc_in;
   logic signed [35:0]            tr_ff, tr_in;
   logic signed [35:0]            ti_ff, ti_in;
   logic signed [65:0]            prod_ff, prod_in;
   logic [63:0]                   sq_ff, sq_in;
   logic [31:0]                   ai_ff, ai_in;
   logic [31:0]                   mag_ff, mag_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [5:0]                    rsp_bin_ff, rsp_bin_in;
   logic [29:0]                   rsp_mag_ff, rsp_mag_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic signed [SAMPLE_BITS-1:0] sample_ext;
   logic signed [32:0]            mul_a, mul_b;
   logic                          ram_we;
   logic [ADDR_W-1:0]             ram_waddr, ram_raddr;
   logic [63:0]                   ram_wdata, ram_rdata;
   logic                          sqrt_start, sqrt_done;
   logic [31:0]                   sqrt_root;
   logic [15:0]                   eq_rom [HALF];

   // sample fitted to SAMPLE_BITS: low bits taken when narrower, zero-extended when wider
   if (SAMPLE_BITS <= 16) begin : g_narrow
      assign sample_ext = signed'(req_sample[SAMPLE_BITS-1:0]);
   end else begin : g_wide
      assign sample_ext = signed'({{(SAMPLE_BITS-16){1'b0}}, req_sample});
   end

   // equalize factors, fixed at elaboration
   for (genvar g = 0; g < HALF; g++) begin : g_eq
      localparam logic [15:0] EQ_VAL = eq_value(32'(HALF), 32'(g));
      assign eq_rom[g] = EQ_VAL;
   end

   // window coefficient for the sample being loaded
   logic [ROM_BITS-1:0]  win_k;
   logic signed [17:0]   hann_w;
   logic [ADDR_W-1:0]    load_rev;
   always_comb begin
      win_k  = ROM_BITS'(ROM_BITS'(load_ff) << (ROM_BITS - LOG2));
      hann_w = (18'sd32768 - 18'(sin_rom(win_k + ROM_BITS'(ROM_QUARTER)))) >>> 1;
      for (int b = 0; b < ADDR_W; b++) begin
         load_rev[ADDR_W-1-b] = load_ff[b];
      end
   end

   // butterfly addressing and twiddle
   logic [ADDR_W-1:0]   hmask, bx, m_idx, ia, ja;
   logic [ROM_BITS-1:0] tw_k;
   logic signed [16:0]  wr, wi;
   always_comb begin
      hmask = (ADDR_W'(1) << stage_ff) - ADDR_W'(1);
      bx    = ADDR_W'(bfly_ff);
      m_idx = bx & hmask;
      ia    = ADDR_W'((bx & ~hmask) << 1) | m_idx;
      ja    = ia | (ADDR_W'(1) << stage_ff);
      tw_k  = ROM_BITS'(ROM_BITS'(m_idx) << (3'(ROM_BITS - 1) - stage_ff));
      wr    = sin_rom(tw_k + ROM_BITS'(ROM_QUARTER));
      wi    = -sin_rom(tw_k);
   end

   // operand views
   logic signed [31:0] b_re, b_im, a_re, a_im, rd_re, rd_im;
   logic [31:0]        abs_re, abs_im;
   logic signed [31:0] x_val;
   logic [47:0]        mag_eq;
   logic [47:0]        mag_fin;
   always_comb begin
      b_re   = signed'(b_ff[31:0]);
      b_im   = signed'(b_ff[63:32]);
      a_re   = signed'(a_ff[31:0]);
      a_im   = signed'(a_ff[63:32]);
      rd_re  = signed'(ram_rdata[31:0]);
      rd_im  = signed'(ram_rdata[63:32]);
      abs_re = rd_re[31] ? 32'(-rd_re) : 32'(rd_re);
      abs_im = rd_im[31] ? 32'(-rd_im) : 32'(rd_im);
      x_val  = win_en_ff ? 32'((prod_ff + 66'sd64) >>> 7) : 32'(sample_ff) <<< 8;
      mag_eq = 48'(prod_ff >>> 16);
      mag_fin = eq_en_ff ? mag_eq : 48'(mag_ff);
   end

   // shared multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_LD_MUL: begin
            mul_a = 33'(sample_ff);
            mul_b = 33'(hann_w);
         end
         ST_BF_M0: begin
            mul_a = 33'(b_re);
            mul_b = 33'(wr);
         end
         ST_BF_M1: begin
            mul_a = 33'(b_im);
            mul_b = 33'(wi);
         end
         ST_BF_M2: begin
            mul_a = 33'(b_re);
            mul_b = 33'(wi);
         end
         ST_BF_M3: begin
            mul_a = 33'(b_im);
            mul_b = 33'(wr);
         end
         ST_OUT_SQ0: begin
            mul_a = signed'({1'b0, abs_re});
            mul_b = signed'({1'b0, abs_re});
         end
         ST_OUT_SQ1: begin
            mul_a = signed'({1'b0, ai_ff});
            mul_b = signed'({1'b0, ai_ff});
         end
         ST_OUT_EQ: begin
            mul_a = signed'({1'b0, mag_ff});
            mul_b = signed'({17'b0, eq_rom[bin_ff]});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // memory port control
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = load_rev;
      ram_wdata = {32'd0, x_val};
      ram_raddr = ja;
      unique case (state_ff)
         ST_LD_WR: begin
            ram_we = 1'b1;
         end
         ST_BF_WA: begin
            ram_we    = 1'b1;
            ram_waddr = ia;
            ram_wdata = {32'(36'(a_im) + ti_ff), 32'(36'(a_re) + tr_ff)};
         end
         ST_BF_WB: begin
            ram_we    = 1'b1;
            ram_waddr = ja;
            ram_wdata = {32'(36'(a_im) - ti_ff), 32'(36'(a_re) - tr_ff)};
         end
         ST_BF_RA: begin
            ram_raddr = ia;
         end
         ST_OUT_RD: begin
            ram_raddr = ADDR_W'(bin_ff);
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
      sqrt_start = (state_ff == ST_OUT_SUM);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      load_in      = load_ff;
      sample_in    = sample_ff;
      win_en_in    = win_en_ff;
      eq_en_in     = eq_en_ff;
      stage_in     = stage_ff;
      bfly_in      = bfly_ff;
      bin_in       = bin_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      acc_in       = acc_ff;
      tr_in        = tr_ff;
      ti_in        = ti_ff;
      sq_in        = sq_ff;
      ai_in        = ai_ff;
      mag_in       = mag_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_bin_in   = rsp_bin_ff;
      rsp_mag_in   = rsp_mag_ff;
      rsp_last_in  = rsp_last_ff;

      // register writes arrive only while idle
      if (csr_valid && csr_ready) begin
         priority if (csr_index == REG_WINDOW_ENABLE) begin
            win_en_in = csr_wdata;
         end else if (csr_index == REG_EQUALIZE_ENABLE) begin
            eq_en_in = csr_wdata;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in = sample_ext;
               state_in  = ST_LD_MUL;
            end
         end
         ST_LD_MUL: begin
            state_in = ST_LD_WR;
         end
         ST_LD_WR: begin
            load_in = load_ff + ADDR_W'(1);
            if (load_ff == ADDR_W'(FRAME_POINTS - 1)) begin
               stage_in = '0;
               bfly_in  = '0;
               state_in = ST_BF_RB;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_BF_RB: begin
            state_in = ST_BF_RA;
         end
         ST_BF_RA: begin
            b_in     = ram_rdata;
            state_in = ST_BF_M0;
         end
         ST_BF_M0: begin
            a_in     = ram_rdata;
            state_in = ST_BF_M1;
         end
         ST_BF_M1: begin
            acc_in   = 50'(prod_ff);
            state_in = ST_BF_M2;
         end
         ST_BF_M2: begin
            tr_in    = 36'((66'(acc_ff) - prod_ff + 66'sd16384) >>> 15);
            state_in = ST_BF_M3;
         end
         ST_BF_M3: begin
            acc_in   = 50'(prod_ff);
            state_in = ST_BF_M4;
         end
         ST_BF_M4: begin
            ti_in    = 36'((66'(acc_ff) + prod_ff + 66'sd16384) >>> 15);
            state_in = ST_BF_WA;
         end
         ST_BF_WA: begin
            state_in = ST_BF_WB;
         end
         ST_BF_WB: begin
            if (bfly_ff == HW'(HALF - 1)) begin
               bfly_in = '0;
               if (stage_ff == 3'(LOG2 - 1)) begin
                  bin_in   = '0;
                  state_in = ST_OUT_RD;
               end else begin
                  stage_in = stage_ff + 3'd1;
                  state_in = ST_BF_RB;
               end
            end else begin
               bfly_in  = bfly_ff + HW'(1);
               state_in = ST_BF_RB;
            end
         end
         ST_OUT_RD: begin
            state_in = ST_OUT_SQ0;
         end
         ST_OUT_SQ0: begin
            ai_in    = abs_im;
            state_in = ST_OUT_SQ1;
         end
         ST_OUT_SQ1: begin
            sq_in    = prod_ff[63:0];
            state_in = ST_OUT_SUM;
         end
         ST_OUT_SUM: begin
            state_in = ST_OUT_SQRT;
         end
         ST_OUT_SQRT: begin
            if (sqrt_done) begin
               mag_in   = sqrt_root;
               state_in = ST_OUT_EQ;
            end
         end
         ST_OUT_EQ: begin
            state_in = ST_OUT_SAT;
         end
         ST_OUT_SAT: begin
            rsp_valid_in = 1'b1;
            rsp_bin_in   = 6'(bin_ff);
            rsp_mag_in   = (mag_fin > 48'(MAG_MAX)) ? MAG_MAX : 30'(mag_fin);
            rsp_last_in  = (bin_ff == HW'(HALF - 1));
            state_in     = ST_OUT_HOLD;
         end
         ST_OUT_HOLD: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  bin_in   = bin_ff + HW'(1);
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         load_ff      <= '0;
         win_en_ff    <= 1'b1;
         eq_en_ff     <= 1'b0;
         stage_ff     <= '0;
         bfly_ff      <= '0;
         bin_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_ff      <= load_in;
         win_en_ff    <= win_en_in;
         eq_en_ff     <= eq_en_in;
         stage_ff     <= stage_in;
         bfly_ff      <= bfly_in;
         bin_ff       <= bin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      acc_ff      <= acc_in;
      tr_ff       <= tr_in;
      ti_ff       <= ti_in;
      prod_ff     <= prod_in;
      sq_ff       <= sq_in;
      ai_ff       <= ai_in;
      mag_ff      <= mag_in;
      rsp_bin_ff  <= rsp_bin_in;
      rsp_mag_ff  <= rsp_mag_in;
      rsp_last_ff <= rsp_last_in;
   end

   // frame memory, complex words {im, re}
   wfms_ram #(
      .WIDTH(64),
      .DEPTH(FRAME_POINTS)
   ) u_frame_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // magnitude square root
   wfms_isqrt u_isqrt (
      .clock(clock),
      .reset(reset),
      .start(sqrt_start),
      .value(sq_ff + prod_ff[63:0]),
      .done (sqrt_done),
      .root (sqrt_root)
   );

   assign req_ready     = (state_ff == ST_IDLE);
   assign csr_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bin_index = rsp_bin_ff;
   assign rsp_magnitude = rsp_mag_ff;
   assign rsp_last_bin  = rsp_last_ff;

endmodule
